>>> design/tmwf_pkg.sv
// Package for the trimmed mean window filter.
// Sizes, derived widths and the sample and result transaction types.
// No dependencies.
`default_nettype none

package tmwf_pkg;

  localparam int WINDOW_LENGTH = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int AXES          = 3;
  localparam int TRIM_COUNT    = 2;

  // Window slot index and sample count widths
  localparam int IDX_W  = $clog2(WINDOW_LENGTH);
  localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
  // Signed window sum with one bit of headroom for the magnitude
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LENGTH) + 1;
  // Divider step counter
  localparam int DCNT_W = $clog2(SUM_W + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_x;
    logic signed [SAMPLE_BITS-1:0] filtered_y;
    logic signed [SAMPLE_BITS-1:0] filtered_z;
    logic                          window_full;
  } result_t;

endpackage

`default_nettype wire

>>> design/tmwf_cell.sv
// One cell of the window chain: holds one three-axis sample.
// Depends on tmwf_pkg.
`default_nettype none

module tmwf_cell (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire tmwf_pkg::sample_t d,
  output tmwf_pkg::sample_t     q
);

  tmwf_pkg::sample_t held;

  // Take the neighbor's sample whenever the chain moves
  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

`default_nettype wire

>>> design/tmwf_divider.sv
// Restoring divider lane, one quotient bit per cycle, quotient truncated
// toward zero. Depends on tmwf_pkg.
`default_nettype none

module tmwf_divider (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [tmwf_pkg::SUM_W-1:0]   dividend,
  input  wire logic        [tmwf_pkg::CNT_W-1:0]   divisor,
  output logic                                     busy,
  output logic signed [tmwf_pkg::SAMPLE_BITS-1:0]  quotient
);

  logic [tmwf_pkg::DCNT_W-1:0] count;
  logic [tmwf_pkg::SUM_W-1:0]  acc;
  logic [tmwf_pkg::CNT_W-1:0]  rem;
  logic [tmwf_pkg::CNT_W-1:0]  dvs;
  logic                        neg;
  logic [tmwf_pkg::CNT_W:0]    trial;
  logic [tmwf_pkg::CNT_W:0]    diff;
  logic                        fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem, acc[tmwf_pkg::SUM_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= tmwf_pkg::DCNT_W'(tmwf_pkg::SUM_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  // Datapath: dividend bits shift out of acc as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[tmwf_pkg::SUM_W-1];
      acc <= dividend[tmwf_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (count != '0) begin
      acc <= {acc[tmwf_pkg::SUM_W-2:0], fits};
      rem <= fits ? diff[tmwf_pkg::CNT_W-1:0] : trial[tmwf_pkg::CNT_W-1:0];
    end
  end

  assign busy     = (count != '0);
  assign quotient = tmwf_pkg::SAMPLE_BITS'(neg ? (~acc + 1'b1) : acc);

endmodule

`default_nettype wire

>>> design/trimmed_mean_window_filter_core.sv
// Trimmed mean window filter: top level with the window chain, the scan
// accumulators, three divider lanes and the result register.
// Depends on tmwf_pkg, tmwf_cell and tmwf_divider.
//
// Usage:
//   sample / sample_valid / sample_ready carry one three-axis reading per
//   transaction. result / result_valid / result_ready return one filtered
//   reading per sample, in order. window_full is 1 once WINDOW_LENGTH
//   samples have been taken; the result is then the window sum less one
//   largest and one smallest value, divided by WINDOW_LENGTH-2. Before that
//   it is the plain mean of the samples taken so far. Both truncate toward
//   zero.
//   Sequence: after a sample is taken the window rotates once around the
//   chain of cells to build sum, minimum and maximum, then the divider
//   lanes run one quotient bit per cycle. One sample is in work at a time
//   and the next can be taken in the cycle after the result is loaded.
//   sample_ready is high whenever no sample is in work, also while a
//   result waits in the output register. A stalled receiver holds the
//   result; a finished sample behind it waits until the register frees.
//   Reset (rst, synchronous) empties the window and drops any result.
`default_nettype none

module trimmed_mean_window_filter_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire tmwf_pkg::sample_t sample,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output tmwf_pkg::result_t      result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic                         accept;
  logic                         shift_en;
  logic [tmwf_pkg::CNT_W-1:0]   fill_count;
  logic                         full;
  logic [tmwf_pkg::IDX_W-1:0]   step;
  logic                         in_window;

  tmwf_pkg::sample_t chain_d [tmwf_pkg::WINDOW_LENGTH];
  tmwf_pkg::sample_t chain_q [tmwf_pkg::WINDOW_LENGTH];

  logic signed [tmwf_pkg::SAMPLE_BITS-1:0] tail_axis [tmwf_pkg::AXES];
  logic signed [tmwf_pkg::SUM_W-1:0]       sum       [tmwf_pkg::AXES];
  logic signed [tmwf_pkg::SAMPLE_BITS-1:0] maxv      [tmwf_pkg::AXES];
  logic signed [tmwf_pkg::SAMPLE_BITS-1:0] minv      [tmwf_pkg::AXES];
  logic signed [tmwf_pkg::SUM_W-1:0]       dividend  [tmwf_pkg::AXES];
  logic signed [tmwf_pkg::SAMPLE_BITS-1:0] quotient  [tmwf_pkg::AXES];
  logic                                    div_busy  [tmwf_pkg::AXES];
  logic [tmwf_pkg::CNT_W-1:0]              divisor;
  logic                                    div_start;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign shift_en     = accept || (state == S_SCAN);
  assign div_start    = (state == S_PREP);

  // Chain of cells: a new sample enters at the head, otherwise the tail
  // wraps around so the window rotates in place
  assign chain_d[0] = accept ? sample : chain_q[tmwf_pkg::WINDOW_LENGTH-1];

  for (genvar c = 0; c < tmwf_pkg::WINDOW_LENGTH; c++) begin : g_cell
    if (c > 0) begin : g_link
      assign chain_d[c] = chain_q[c-1];
    end
    tmwf_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d        (chain_d[c]),
      .q        (chain_q[c])
    );
  end

  assign tail_axis[0] = chain_q[tmwf_pkg::WINDOW_LENGTH-1].sample_x;
  assign tail_axis[1] = chain_q[tmwf_pkg::WINDOW_LENGTH-1].sample_y;
  assign tail_axis[2] = chain_q[tmwf_pkg::WINDOW_LENGTH-1].sample_z;

  // Written samples sit in the first fill_count cells; the tail shows them
  // in the last fill_count scan steps
  assign in_window = (tmwf_pkg::CNT_W'(step) >=
                      (tmwf_pkg::CNT_W'(tmwf_pkg::WINDOW_LENGTH) - fill_count));

  // Scan accumulators, one set per axis
  always_ff @(posedge clk) begin
    for (int a = 0; a < tmwf_pkg::AXES; a++) begin
      if (accept) begin
        sum[a]  <= '0;
        maxv[a] <= {1'b1, {(tmwf_pkg::SAMPLE_BITS-1){1'b0}}};
        minv[a] <= {1'b0, {(tmwf_pkg::SAMPLE_BITS-1){1'b1}}};
      end else if (state == S_SCAN && in_window) begin
        sum[a] <= sum[a] + tmwf_pkg::SUM_W'(tail_axis[a]);
        if (tail_axis[a] > maxv[a]) begin
          maxv[a] <= tail_axis[a];
        end
        if (tail_axis[a] < minv[a]) begin
          minv[a] <= tail_axis[a];
        end
      end
    end
  end

  // Trim and pick the divisor
  always_comb begin
    for (int a = 0; a < tmwf_pkg::AXES; a++) begin
      dividend[a] = full ? (sum[a] - tmwf_pkg::SUM_W'(maxv[a])
                            - tmwf_pkg::SUM_W'(minv[a]))
                         : sum[a];
    end
    divisor = full ? tmwf_pkg::CNT_W'(tmwf_pkg::WINDOW_LENGTH - tmwf_pkg::TRIM_COUNT)
                   : fill_count;
  end

  for (genvar a = 0; a < tmwf_pkg::AXES; a++) begin : g_lane
    tmwf_divider u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (dividend[a]),
      .divisor  (divisor),
      .busy     (div_busy[a]),
      .quotient (quotient[a])
    );
  end

  // Sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      full         <= 1'b0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      // Receiver took the result; the output step reloads it on its own
      if (result_valid && result_ready && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            step <= '0;
            if (fill_count != tmwf_pkg::CNT_W'(tmwf_pkg::WINDOW_LENGTH)) begin
              fill_count <= fill_count + 1'b1;
            end
            full  <= (fill_count >= tmwf_pkg::CNT_W'(tmwf_pkg::WINDOW_LENGTH - 1));
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          step <= step + 1'b1;
          if (step == tmwf_pkg::IDX_W'(tmwf_pkg::WINDOW_LENGTH - 1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy[0]) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!result_valid || result_ready)) begin
      result.filtered_x  <= quotient[0];
      result.filtered_y  <= quotient[1];
      result.filtered_z  <= quotient[2];
      result.window_full <= full;
    end
  end

  // Checks
  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_OUT))
    else $error("result_valid rose outside the output step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= tmwf_pkg::CNT_W'(tmwf_pkg::WINDOW_LENGTH))
    else $error("fill_count above window length");

  a_full_consistent: assert property (@(posedge clk) disable iff (rst)
    full |-> (fill_count == tmwf_pkg::CNT_W'(tmwf_pkg::WINDOW_LENGTH)))
    else $error("full flag without a full window");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (div_busy[0] == div_busy[1]) && (div_busy[0] == div_busy[2]))
    else $error("divider lanes out of step");

  a_div_idle_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_IDLE) |-> !div_busy[0])
    else $error("divider busy outside the divide step");

endmodule

`default_nettype wire
